// ===== src/mev_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh element volume package
// Shared widths, the element kind type and the stage enable pair used by the
// arithmetic stages of the element volume pipeline.
// ----------------------------------------------------------------------------
package mev_pkg;

  localparam int COORD_W    = 16;
  localparam int EDGE_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * EDGE_W;
  localparam int MINOR_W    = PROD_W + 1;
  localparam int MAG_W      = PROD_W;
  localparam int TERM_W     = 52;
  localparam int DET_W      = TERM_W + 2;
  localparam int AREA_W     = MAG_W + 1;
  localparam int VOL_W      = 52;
  localparam int AREA_SHIFT = 7;
  localparam int NUM_ST     = 8;

  typedef enum logic [1:0] {
    KIND_TRI  = 2'd0,
    KIND_QUAD = 2'd1,
    KIND_TET  = 2'd2,
    KIND_HEX  = 2'd3
  } kind_e;

  typedef struct packed {
    logic en_a;
    logic en_b;
  } st_en_t;

endpackage

// ===== src/mesh_element_volume.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh element volume
// Area or volume of one mesh element (triangle, convex quad, tetrahedron or
// cuboid hexahedron) from signed Q8.8 corner coordinates, unsigned Q.24 out.
// One beat per cycle is taken unless the output stalls; the pipeline has eight
// register stages with a per-stage valid bit and a ready chain that fills
// bubbles while the output stalls.
// Reset clears the valid bits and sets the element kind to triangle.
// ----------------------------------------------------------------------------
module mesh_element_volume (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [1:0]                           cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [mev_pkg::COORD_W-1:0]   p0_x_i,
  input  logic signed [mev_pkg::COORD_W-1:0]   p0_y_i,
  input  logic signed [mev_pkg::COORD_W-1:0]   p0_z_i,
  input  logic signed [mev_pkg::COORD_W-1:0]   p1_x_i,
  input  logic signed [mev_pkg::COORD_W-1:0]   p1_y_i,
  input  logic signed [mev_pkg::COORD_W-1:0]   p1_z_i,
  input  logic signed [mev_pkg::COORD_W-1:0]   p2_x_i,
  input  logic signed [mev_pkg::COORD_W-1:0]   p2_y_i,
  input  logic signed [mev_pkg::COORD_W-1:0]   p2_z_i,
  input  logic signed [mev_pkg::COORD_W-1:0]   p3_x_i,
  input  logic signed [mev_pkg::COORD_W-1:0]   p3_y_i,
  input  logic signed [mev_pkg::COORD_W-1:0]   p3_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [mev_pkg::VOL_W-1:0]            volume_o
);

  localparam int NSt = mev_pkg::NUM_ST;
  localparam int EW  = mev_pkg::EDGE_W;

  mev_pkg::kind_e element_kind_q;
  mev_pkg::kind_e kind_q [NSt];

  logic [NSt-1:0] v_d, v_q, en;

  logic signed [EW-1:0] ea_d [3], eb_d [3], ec_d [3];
  logic signed [EW-1:0] ea_q [3], eb_q [3], ec_q [3];

  logic signed [EW-1:0]                  a_x [3];
  logic signed [mev_pkg::MINOR_W-1:0]    m_x [3];
  logic signed [mev_pkg::MINOR_W-1:0]    x20, x21, x01;
  logic signed [mev_pkg::DET_W-1:0]      det;
  logic        [mev_pkg::AREA_W-1:0]     area;
  logic signed [mev_pkg::DET_W-1:0]      det_abs;
  logic        [mev_pkg::VOL_W-1:0]      size_d, size5_q, size6_q, size7_q;
  logic        [mev_pkg::VOL_W-1:0]      quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_kind_q <= mev_pkg::KIND_TRI;
    end else if (cfg_we_i) begin
      element_kind_q <= mev_pkg::kind_e'(cfg_wdata_i);
    end
  end

  always_comb begin
    en[NSt-1] = !v_q[NSt-1] || out_ready_i;
    for (int k = NSt - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    for (int k = 0; k < NSt; k++) begin
      if (!en[k]) begin
        v_d[k] = v_q[k];
      end else if (k == 0) begin
        v_d[k] = in_valid_i;
      end else begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NSt; k++) begin
      if (en[k]) begin
        kind_q[k] <= (k == 0) ? element_kind_q : kind_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  assign ea_d[0] = EW'(p1_x_i) - EW'(p0_x_i);
  assign ea_d[1] = EW'(p1_y_i) - EW'(p0_y_i);
  assign ea_d[2] = EW'(p1_z_i) - EW'(p0_z_i);
  assign eb_d[0] = EW'(p2_x_i) - EW'(p0_x_i);
  assign eb_d[1] = EW'(p2_y_i) - EW'(p0_y_i);
  assign eb_d[2] = EW'(p2_z_i) - EW'(p0_z_i);
  assign ec_d[0] = EW'(p3_x_i) - EW'(p0_x_i);
  assign ec_d[1] = EW'(p3_y_i) - EW'(p0_y_i);
  assign ec_d[2] = EW'(p3_z_i) - EW'(p0_z_i);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      ea_q <= ea_d;
      eb_q <= eb_d;
      ec_q <= ec_d;
    end
  end

  mev_cross u_cross (
    .clk_i (clk_i),
    .st_i  ('{en_a: en[1], en_b: en[2]}),
    .a_i   (ea_q),
    .b_i   (eb_q),
    .c_i   (ec_q),
    .a_o   (a_x),
    .m_o   (m_x),
    .x20_o (x20),
    .x21_o (x21),
    .x01_o (x01)
  );

  mev_det u_det (
    .clk_i  (clk_i),
    .st_i   ('{en_a: en[3], en_b: en[4]}),
    .kind_i (kind_q[3]),
    .a_i    (a_x),
    .m_i    (m_x),
    .x20_i  (x20),
    .x21_i  (x21),
    .x01_i  (x01),
    .det_o  (det),
    .area_o (area)
  );

  assign det_abs = det[mev_pkg::DET_W-1] ? -det : det;

  always_comb begin
    if (kind_q[4] inside {mev_pkg::KIND_TRI, mev_pkg::KIND_QUAD}) begin
      size_d = mev_pkg::VOL_W'(area) << mev_pkg::AREA_SHIFT;
    end else begin
      size_d = det_abs[mev_pkg::VOL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      size5_q <= size_d;
    end
    if (en[6]) begin
      size6_q <= size5_q;
    end
    if (en[7]) begin
      size7_q <= size6_q;
    end
  end

  mev_div3 u_div3 (
    .clk_i  (clk_i),
    .st_i   ('{en_a: en[6], en_b: en[7]}),
    .size_i (size5_q),
    .quot_o (quot)
  );

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NSt-1];
  assign volume_o    = (kind_q[NSt-1] == mev_pkg::KIND_TET) ? quot : size7_q;

endmodule

// ===== src/mev_cross.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh element volume: cross products
// Two pipeline stages that form the pairwise products of the edge vectors and
// then the 2x2 minors used by both the area and the determinant paths.
// ----------------------------------------------------------------------------
module mev_cross (
  input  logic                                 clk_i,
  input  mev_pkg::st_en_t                      st_i,
  input  logic signed [mev_pkg::EDGE_W-1:0]    a_i [3],
  input  logic signed [mev_pkg::EDGE_W-1:0]    b_i [3],
  input  logic signed [mev_pkg::EDGE_W-1:0]    c_i [3],
  output logic signed [mev_pkg::EDGE_W-1:0]    a_o [3],
  output logic signed [mev_pkg::MINOR_W-1:0]   m_o [3],
  output logic signed [mev_pkg::MINOR_W-1:0]   x20_o,
  output logic signed [mev_pkg::MINOR_W-1:0]   x21_o,
  output logic signed [mev_pkg::MINOR_W-1:0]   x01_o
);

  logic signed [mev_pkg::PROD_W-1:0]  pa_q, pb_q, pc_q, pd_q, pe_q, pf_q;
  logic signed [mev_pkg::PROD_W-1:0]  pg_q, ph_q, pi_q, pj_q;
  logic signed [mev_pkg::EDGE_W-1:0]  a1_q [3];
  logic signed [mev_pkg::EDGE_W-1:0]  a2_q [3];
  logic signed [mev_pkg::MINOR_W-1:0] m_q [3];
  logic signed [mev_pkg::MINOR_W-1:0] x20_q, x21_q, x01_q;

  function automatic logic signed [mev_pkg::MINOR_W-1:0] MINOR_EXT(
    input logic signed [mev_pkg::PROD_W-1:0] p
  );
    return mev_pkg::MINOR_W'(p);
  endfunction

  always_ff @(posedge clk_i) begin
    if (st_i.en_a) begin
      pa_q <= b_i[1] * c_i[2];
      pb_q <= b_i[2] * c_i[1];
      pc_q <= b_i[0] * c_i[2];
      pd_q <= b_i[2] * c_i[0];
      pe_q <= b_i[0] * c_i[1];
      pf_q <= b_i[1] * c_i[0];
      pg_q <= c_i[0] * a_i[1];
      ph_q <= c_i[1] * a_i[0];
      pi_q <= a_i[0] * b_i[1];
      pj_q <= a_i[1] * b_i[0];
      a1_q <= a_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_i.en_b) begin
      m_q[0] <= MINOR_EXT(pa_q) - MINOR_EXT(pb_q);
      m_q[1] <= MINOR_EXT(pc_q) - MINOR_EXT(pd_q);
      m_q[2] <= MINOR_EXT(pe_q) - MINOR_EXT(pf_q);
      x20_q  <= MINOR_EXT(pg_q) - MINOR_EXT(ph_q);
      x21_q  <= MINOR_EXT(pf_q) - MINOR_EXT(pe_q);
      x01_q  <= MINOR_EXT(pi_q) - MINOR_EXT(pj_q);
      a2_q   <= a1_q;
    end
  end

  assign a_o   = a2_q;
  assign m_o   = m_q;
  assign x20_o = x20_q;
  assign x21_o = x21_q;
  assign x01_o = x01_q;

endmodule

// ===== src/mev_det.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh element volume: determinant and area
// Two pipeline stages that expand the determinant along the first edge vector
// and, for the planar kinds, take one cross product magnitude (triangle) or sum two (quad).
// ----------------------------------------------------------------------------
module mev_det (
  input  logic                                 clk_i,
  input  mev_pkg::st_en_t                      st_i,
  input  mev_pkg::kind_e                       kind_i,
  input  logic signed [mev_pkg::EDGE_W-1:0]    a_i [3],
  input  logic signed [mev_pkg::MINOR_W-1:0]   m_i [3],
  input  logic signed [mev_pkg::MINOR_W-1:0]   x20_i,
  input  logic signed [mev_pkg::MINOR_W-1:0]   x21_i,
  input  logic signed [mev_pkg::MINOR_W-1:0]   x01_i,
  output logic signed [mev_pkg::DET_W-1:0]     det_o,
  output logic        [mev_pkg::AREA_W-1:0]    area_o
);

  logic signed [mev_pkg::TERM_W-1:0] t_q [3];
  logic        [mev_pkg::MAG_W-1:0]  ax20_q, ax21_q, ax01_q;
  logic signed [mev_pkg::DET_W-1:0]  det_q;
  logic        [mev_pkg::AREA_W-1:0] area_q;

  function automatic logic [mev_pkg::MAG_W-1:0] MAG(
    input logic signed [mev_pkg::MINOR_W-1:0] x
  );
    logic signed [mev_pkg::MINOR_W-1:0] y;
    y = x[mev_pkg::MINOR_W-1] ? -x : x;
    return y[mev_pkg::MAG_W-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (st_i.en_a) begin
      t_q[0] <= a_i[0] * m_i[0];
      t_q[1] <= a_i[1] * m_i[1];
      t_q[2] <= a_i[2] * m_i[2];
      ax20_q <= MAG(x20_i);
      ax21_q <= MAG(x21_i);
      ax01_q <= MAG(x01_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_i.en_b) begin
      det_q <= mev_pkg::DET_W'(t_q[0]) - mev_pkg::DET_W'(t_q[1])
             + mev_pkg::DET_W'(t_q[2]);
      if (kind_i == mev_pkg::KIND_TRI) begin
        area_q <= mev_pkg::AREA_W'(ax01_q);
      end else begin
        area_q <= mev_pkg::AREA_W'(ax20_q) + mev_pkg::AREA_W'(ax21_q);
      end
    end
  end

  assign det_o  = det_q;
  assign area_o = area_q;

endmodule

// ===== src/mev_div3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh element volume: divide by six
// Two pipeline stages of byte-wise long division by three applied to the
// magnitude shifted right by one, giving the truncated sixth.
// ----------------------------------------------------------------------------
module mev_div3 (
  input  logic                            clk_i,
  input  mev_pkg::st_en_t                 st_i,
  input  logic [mev_pkg::VOL_W-1:0]       size_i,
  output logic [mev_pkg::VOL_W-1:0]       quot_o
);

  localparam int DigW   = 8;
  localparam int NumDig = (mev_pkg::VOL_W - 1 + DigW - 1) / DigW;
  localparam int HiDig  = (NumDig + 1) / 2;
  localparam int LoDig  = NumDig - HiDig;
  localparam int PadW   = NumDig * DigW;
  localparam int HiW    = HiDig * DigW;
  localparam int LoW    = LoDig * DigW;

  logic [PadW-1:0]  y;
  logic [HiW-1:0]   qhi_d, qhi_q;
  logic [LoW-1:0]   ylo_q, qlo_d;
  logic [1:0]       rhi_d, rhi_q, rlo;
  logic [PadW-1:0]  quot_q;

  function automatic logic [DigW-1:0] DIV3(input logic [DigW+1:0] v);
    logic [2*(DigW+2):0] p;
    p = (2*(DigW+2)+1)'(v) * (2*(DigW+2)+1)'(683);
    return p[DigW+10:11];
  endfunction

  function automatic logic [1:0] REM3(input logic [DigW+1:0] v,
                                      input logic [DigW-1:0] q);
    logic [DigW+1:0] t;
    t = v - ((DigW+2)'(q) + (DigW+2)'({q, 1'b0}));
    return t[1:0];
  endfunction

  assign y = PadW'(size_i[mev_pkg::VOL_W-1:1]);

  always_comb begin
    logic [DigW+1:0] v;
    logic [DigW-1:0] q;
    rhi_d = 2'd0;
    qhi_d = '0;
    for (int i = HiDig - 1; i >= 0; i--) begin
      v = {rhi_d, y[LoW + i*DigW +: DigW]};
      q = DIV3(v);
      rhi_d = REM3(v, q);
      qhi_d[i*DigW +: DigW] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_i.en_a) begin
      qhi_q <= qhi_d;
      rhi_q <= rhi_d;
      ylo_q <= y[LoW-1:0];
    end
  end

  always_comb begin
    logic [DigW+1:0] v;
    logic [DigW-1:0] q;
    rlo   = rhi_q;
    qlo_d = '0;
    for (int i = LoDig - 1; i >= 0; i--) begin
      v = {rlo, ylo_q[i*DigW +: DigW]};
      q = DIV3(v);
      rlo = REM3(v, q);
      qlo_d[i*DigW +: DigW] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_i.en_b) begin
      quot_q <= {qhi_q, qlo_d};
    end
  end

  assign quot_o = quot_q[mev_pkg::VOL_W-1:0];

endmodule

// ===== src/mev_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh element volume checker
// Port-level assertions on output stalls, ready behavior, result range and the
// low bits of planar areas, attached to the top level by a bind statement.
// ----------------------------------------------------------------------------
module mev_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [1:0]                    cfg_wdata_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [mev_pkg::VOL_W-1:0]     volume_o
);

  mev_pkg::kind_e kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= mev_pkg::KIND_TRI;
    end else if (cfg_we_i) begin
      kind_q <= mev_pkg::kind_e'(cfg_wdata_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(volume_o))
    else $error("Stalled output beat changed or vanished.");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("Input not ready although the output stage can move.");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !volume_o[mev_pkg::VOL_W-1])
    else $error("Result exceeds its range.");

  a_area_lsb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_q == mev_pkg::KIND_TRI || kind_q == mev_pkg::KIND_QUAD)
    |-> volume_o[mev_pkg::AREA_SHIFT-1:0] == '0)
    else $error("Planar area has nonzero low fraction bits.");

endmodule

bind mesh_element_volume mev_checker u_mev_checker (.*);
